[sv/tcp_handshake_ack_tracker_defines.svh]
// ----------------------------------------------------------------------------
// TCP handshake tracker assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i and held off
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TCP_HANDSHAKE_ACK_TRACKER_DEFINES_SVH
`define TCP_HANDSHAKE_ACK_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define THT_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define THT_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[sv/tht_pkg.sv]
// ----------------------------------------------------------------------------
// TCP handshake tracker package
// Codes, queue sizing and the item and result records shared by the tracker.
// ----------------------------------------------------------------------------
package tht_pkg;

  // Depth of the queue between the front and the back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Action codes of an input item.
  localparam logic [1:0] ActRecv    = 2'd0;
  localparam logic [1:0] ActConnect = 2'd1;
  localparam logic [1:0] ActNext    = 2'd2;

  // Connection states.
  localparam logic [1:0] LinkNone    = 2'd0;
  localparam logic [1:0] LinkSynRcvd = 2'd1;
  localparam logic [1:0] LinkEst     = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CfgLocalPort = 2'd0;
  localparam logic [1:0] CfgInitSeq   = 2'd1;
  localparam logic [1:0] CfgClientLen = 2'd2;
  localparam logic [1:0] CfgServerLen = 2'd3;

  // Payload kinds of an outgoing header.
  localparam logic [1:0] KindEmpty  = 2'd0;
  localparam logic [1:0] KindClient = 2'd1;
  localparam logic [1:0] KindServer = 2'd2;

  // Reset payload lengths in bytes.
  localparam logic [15:0] ClientLenReset = 16'd45;
  localparam logic [15:0] ServerLenReset = 16'd22;

  // Classified operation of an item.
  typedef enum logic [1:0] {
    OP_NOP,
    OP_RX,
    OP_CONNECT,
    OP_NEXT
  } op_e;

  // Classified item as it travels through the queue.
  typedef struct packed {
    op_e         op;
    logic        syn;
    logic        ack;
    logic [31:0] seq;
    logic [31:0] ackn;
    logic [15:0] bytes;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        packet_valid;
    logic        syn;
    logic        ack;
    logic [31:0] seq;
    logic [31:0] ackn;
    logic [1:0]  kind;
    logic        forward;
    logic [1:0]  conn_state;
    logic [31:0] acked;
  } result_t;

endpackage

[sv/tcp_handshake_ack_tracker.sv]
// ----------------------------------------------------------------------------
// TCP handshake tracker
// Simplified TCP endpoint that follows the three-way handshake, tracks own
// and peer sequence numbers and emits one header result per input item.
// ----------------------------------------------------------------------------
// Usage:
// Input items (action and received header fields) arrive on the in_ channel
// and each yields exactly one result item on the out_ channel, in order.
// Configuration writes use the cfg_ channel, which is always ready; they are
// to be issued only while no item is in flight.
// The front end classifies each item as it is written into the queue; the
// back end then takes it from the queue, updates the connection state and
// loads the output register.
// Throughput is one item per cycle while out_ready_i stays high; the queue
// and output register let both sides stall apart.
// When the receiver holds out_ready_i low the result stays in the output
// register, further items gather in the two-entry queue, and in_ready_o
// falls once the queue is full.
// Reset clears the connection state, sequence numbers and queue and loads
// the payload lengths 45 and 22 bytes.
// ----------------------------------------------------------------------------
module tcp_handshake_ack_tracker import tht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic        in_syn_i,
  input  logic        in_ack_i,
  input  logic [31:0] in_seq_number_i,
  input  logic [31:0] in_ack_number_i,
  input  logic [18:0] in_payload_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        packet_valid_o,
  output logic        out_syn_o,
  output logic        out_ack_o,
  output logic [31:0] out_seq_number_o,
  output logic [31:0] out_ack_number_o,
  output logic [1:0]  payload_kind_o,
  output logic        forward_o,
  output logic [1:0]  conn_state_o,
  output logic [31:0] acked_sequence_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_valid;
  item_t   front_item;
  item_t   queue_item;
  result_t res;

  // Configuration is always taken.
  assign cfg_ready_o = 1'b1;

  tht_front u_front (
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .in_syn_i          (in_syn_i),
    .in_ack_i          (in_ack_i),
    .in_seq_number_i   (in_seq_number_i),
    .in_ack_number_i   (in_ack_number_i),
    .in_payload_bits_i (in_payload_bits_i),
    .q_full_i          (q_full),
    .push_o            (push),
    .item_o            (front_item)
  );

  tht_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (queue_item)
  );

  tht_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .item_i      (queue_item),
    .pop_o       (pop),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  // Result fields onto their ports.
  assign packet_valid_o   = res.packet_valid;
  assign out_syn_o        = res.syn;
  assign out_ack_o        = res.ack;
  assign out_seq_number_o = res.seq;
  assign out_ack_number_o = res.ackn;
  assign payload_kind_o   = res.kind;
  assign forward_o        = res.forward;
  assign conn_state_o     = res.conn_state;
  assign acked_sequence_o = res.acked;

endmodule

[sv/tht_front.sv]
// ----------------------------------------------------------------------------
// TCP handshake tracker front end
// Accepts input items, decodes the action and converts the payload size
// from bits to bytes before the item is queued.
// ----------------------------------------------------------------------------
module tht_front import tht_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic        in_syn_i,
  input  logic        in_ack_i,
  input  logic [31:0] in_seq_number_i,
  input  logic [31:0] in_ack_number_i,
  input  logic [18:0] in_payload_bits_i,
  input  logic        q_full_i,
  output logic        push_o,
  output item_t       item_o
);

  // An item is taken whenever the queue has room.
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    // Header fields pass on; the byte count drops the three low bits.
    item_o.syn   = in_syn_i;
    item_o.ack   = in_ack_i;
    item_o.seq   = in_seq_number_i;
    item_o.ackn  = in_ack_number_i;
    item_o.bytes = in_payload_bits_i[18:3];

    // Decode the action into an operation; the spare code does nothing.
    unique case (action_i)
      ActRecv:    item_o.op = OP_RX;
      ActConnect: item_o.op = OP_CONNECT;
      ActNext:    item_o.op = OP_NEXT;
      default:    item_o.op = OP_NOP;
    endcase
  end

endmodule

[sv/tht_queue.sv]
// ----------------------------------------------------------------------------
// TCP handshake tracker item queue
// A short first-in first-out queue of classified items between the front
// end and the back end.
// ----------------------------------------------------------------------------
`include "tcp_handshake_ack_tracker_defines.svh"

module tht_queue import tht_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o
);

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update, with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Queue bookkeeping checks.
  `THT_ASSERT_IMP(a_no_pop_empty, pop_i, cnt_q != '0, "item taken from an empty queue")
  `THT_ASSERT_NXT(a_cnt_grows, push_i && !pop_i, cnt_q == QCntW'($past(cnt_q) + 1'b1), "fill count did not grow on push")

endmodule

[sv/tht_back.sv]
// ----------------------------------------------------------------------------
// TCP handshake tracker back end
// Holds the connection state and configuration, carries out one queued item
// per cycle when its output register is free or being read, and keeps the result there.
// ----------------------------------------------------------------------------
`include "tcp_handshake_ack_tracker_defines.svh"

module tht_back import tht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  item_t       item_i,
  output logic        pop_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     res_o
);

  logic [1:0]  link_q, link_d;
  logic        server_q, server_d;
  logic [31:0] own_q, own_d;
  logic [31:0] peer_q, peer_d;
  logic [31:0] acked_q, acked_d;
  logic [15:0] client_len_q, client_len_d;
  logic [15:0] server_len_q, server_len_d;
  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d;
  logic [31:0] seq_inc;

  // A queued item moves on when the output register is free or being read.
  assign pop_o   = q_valid_i && (!out_valid_q || out_ready_i);
  assign seq_inc = item_i.seq + 32'd1;

  // Item execution and configuration writes.
  always_comb begin
    link_d       = link_q;
    server_d     = server_q;
    own_d        = own_q;
    peer_d       = peer_q;
    acked_d      = acked_q;
    client_len_d = client_len_q;
    server_len_d = server_len_q;
    res_d        = '0;

    if (pop_o) begin
      unique case (item_i.op)
        OP_RX: begin
          unique case (link_q)
            LinkNone: begin
              if (item_i.syn && !item_i.ack) begin
                // Passive open: answer with SYN+ACK and become the server.
                server_d           = 1'b1;
                peer_d             = seq_inc;
                link_d             = LinkSynRcvd;
                res_d.packet_valid = 1'b1;
                res_d.syn          = 1'b1;
                res_d.ack          = 1'b1;
                res_d.seq          = own_q;
                res_d.ackn         = seq_inc;
                own_d              = own_q + 32'd1;
              end else if (item_i.syn && item_i.ack) begin
                // Active open completes: acknowledge the SYN+ACK.
                server_d           = 1'b0;
                peer_d             = seq_inc;
                link_d             = LinkEst;
                res_d.packet_valid = 1'b1;
                res_d.ack          = 1'b1;
                res_d.seq          = own_q;
                res_d.ackn         = seq_inc;
                acked_d            = own_q;
              end
            end
            LinkSynRcvd: begin
              if (!item_i.syn && item_i.ack) begin
                acked_d = own_q;
                link_d  = LinkEst;
              end
            end
            LinkEst: begin
              if (!item_i.ack) begin
                // Data is always forwarded; only in-order data is acknowledged.
                res_d.forward = 1'b1;
                if (item_i.seq == peer_q) begin
                  peer_d             = peer_q + {16'd0, item_i.bytes};
                  res_d.packet_valid = 1'b1;
                  res_d.ack          = 1'b1;
                  res_d.seq          = own_q;
                  res_d.ackn         = peer_q + {16'd0, item_i.bytes};
                end
              end else if (item_i.ackn > acked_q) begin
                acked_d = item_i.ackn;
              end
            end
            default: begin
            end
          endcase
        end
        OP_CONNECT: begin
          res_d.packet_valid = 1'b1;
          res_d.syn          = 1'b1;
          res_d.seq          = own_q;
          own_d              = own_q + 32'd1;
        end
        OP_NEXT: begin
          res_d.packet_valid = 1'b1;
          res_d.seq          = own_q;
          if (link_q == LinkEst) begin
            if (server_q) begin
              res_d.kind = KindServer;
              own_d      = own_q + {16'd0, server_len_q};
            end else begin
              res_d.kind = KindClient;
              own_d      = own_q + {16'd0, client_len_q};
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgLocalPort: begin
          // The port is not part of the emitted header fields, so nothing is kept.
        end
        CfgInitSeq: begin
          own_d   = cfg_data_i;
          acked_d = cfg_data_i;
        end
        CfgClientLen: client_len_d = cfg_data_i[15:0];
        CfgServerLen: server_len_d = cfg_data_i[15:0];
        default: begin
        end
      endcase
    end

    res_d.conn_state = link_d;
    res_d.acked      = acked_d;
  end

  // Output register hand-over.
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q       <= LinkNone;
      server_q     <= 1'b0;
      own_q        <= '0;
      peer_q       <= '0;
      acked_q      <= '0;
      client_len_q <= ClientLenReset;
      server_len_q <= ServerLenReset;
      out_valid_q  <= 1'b0;
    end else begin
      link_q       <= link_d;
      server_q     <= server_d;
      own_q        <= own_d;
      peer_q       <= peer_d;
      acked_q      <= acked_d;
      client_len_q <= client_len_d;
      server_len_q <= server_len_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // Result consistency checks.
  `THT_ASSERT_NXT(a_pop_fills_out, pop_o, out_valid_q, "executed item left no result")
  `THT_ASSERT_IMP(a_fwd_established, out_valid_q && res_q.forward, res_q.conn_state == LinkEst, "forwarded data outside an open connection")
  `THT_ASSERT_IMP(a_synack_state, out_valid_q && res_q.syn && res_q.ack, res_q.conn_state == LinkSynRcvd, "SYN+ACK sent without entering SYN received")
  `THT_ASSERT_IMP(a_empty_clean, out_valid_q && !res_q.packet_valid, !res_q.syn && !res_q.ack && res_q.seq == '0 && res_q.ackn == '0 && res_q.kind == KindEmpty, "header fields set with no packet")

endmodule

[bench/tcp_handshake_ack_tracker_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP handshake tracker testbench
// Drives items with random gaps and checks every result field against a
// behavioural model of the endpoint. A short table covers the handshake and
// the corner cases, then several configuration phases follow with random
// traffic, one of them with a long output stall to fill the block.
// ----------------------------------------------------------------------------
module tcp_handshake_ack_tracker_test;
  import tht_pkg::*;

  // Action code that the block does not know.
  localparam logic [1:0] ActUnknown = 2'd3;

  localparam int unsigned NumPhases   = 5;
  localparam int unsigned PhaseItems  = 115;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned WatchLimit  = 2000;

  // Which side of the handshake a table row belongs to.
  typedef enum logic [1:0] {
    ROLE_ANY,
    ROLE_SERVER,
    ROLE_CLIENT
  } role_e;

  // One input item as the sender offers it.
  typedef struct packed {
    logic [1:0]  action;
    logic        syn;
    logic        ack;
    logic [31:0] seq;
    logic [31:0] ackn;
    logic [18:0] bits;
  } segment_t;

  // One row of the directed table.
  typedef struct packed {
    role_e    role;
    segment_t seg;
    logic     seq_from_peer;
    logic     typed;
    result_t  hdr;
  } drill_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic        in_syn_i;
  logic        in_ack_i;
  logic [31:0] in_seq_number_i;
  logic [31:0] in_ack_number_i;
  logic [18:0] in_payload_bits_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        packet_valid_o;
  logic        out_syn_o;
  logic        out_ack_o;
  logic [31:0] out_seq_number_o;
  logic [31:0] out_ack_number_o;
  logic [1:0]  payload_kind_o;
  logic        forward_o;
  logic [1:0]  conn_state_o;
  logic [31:0] acked_sequence_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  tcp_handshake_ack_tracker u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .in_syn_i         (in_syn_i),
    .in_ack_i         (in_ack_i),
    .in_seq_number_i  (in_seq_number_i),
    .in_ack_number_i  (in_ack_number_i),
    .in_payload_bits_i(in_payload_bits_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .packet_valid_o   (packet_valid_o),
    .out_syn_o        (out_syn_o),
    .out_ack_o        (out_ack_o),
    .out_seq_number_o (out_seq_number_o),
    .out_ack_number_o (out_ack_number_o),
    .payload_kind_o   (payload_kind_o),
    .forward_o        (forward_o),
    .conn_state_o     (conn_state_o),
    .acked_sequence_o (acked_sequence_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Endpoint state and configuration as the model sees them.
  logic [1:0]  link_st;
  logic        srv_role;
  logic [31:0] own_seq;
  logic [31:0] peer_seq;
  logic [31:0] acked_hi;
  logic [15:0] port_cfg;
  logic [31:0] isn_cfg;
  logic [15:0] cli_len;
  logic [15:0] srv_len;

  // Headers still owed by the block, oldest first.
  result_t    expected_hdrs[$];
  drill_row_t drill[$];

  int  n_items;
  int  n_results;
  int  n_headers;
  int  n_forwards;
  int  n_writes;
  int  n_errors;
  int  idle_cycles;
  bit  quiet_tx;
  bit  hold_pending;

  // Free-running clock, 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap length: mostly none, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Header emitted from the current own sequence; the caller advances it.
  function automatic result_t header_at(input logic syn, input logic ack,
                                        input logic [1:0] kind);
    result_t h;
    h              = '0;
    h.packet_valid = 1'b1;
    h.syn          = syn;
    h.ack          = ack;
    h.seq          = own_seq;
    h.ackn         = ack ? peer_seq : 32'd0;
    h.kind         = kind;
    return h;
  endfunction

  // Work out the result of one item and move the endpoint state on.
  function automatic result_t advance_endpoint(input segment_t seg);
    result_t     hdr;
    logic [15:0] nbytes;
    hdr    = '0;
    nbytes = seg.bits[18:3];
    if (seg.action == ActRecv) begin
      if (link_st == LinkNone) begin
        if (seg.syn && !seg.ack) begin
          srv_role = 1'b1;
          peer_seq = seg.seq + 32'd1;
          link_st  = LinkSynRcvd;
          hdr      = header_at(1'b1, 1'b1, KindEmpty);
          own_seq  = own_seq + 32'd1;
        end else if (seg.syn && seg.ack) begin
          srv_role = 1'b0;
          peer_seq = seg.seq + 32'd1;
          link_st  = LinkEst;
          hdr      = header_at(1'b0, 1'b1, KindEmpty);
          acked_hi = own_seq;
        end
      end else if (link_st == LinkSynRcvd) begin
        if (!seg.syn && seg.ack) begin
          acked_hi = own_seq;
          link_st  = LinkEst;
        end
      end else if (link_st == LinkEst) begin
        if (!seg.ack) begin
          // In-order data is acknowledged; any data is forwarded.
          if (seg.seq == peer_seq) begin
            peer_seq = peer_seq + {16'd0, nbytes};
            hdr      = header_at(1'b0, 1'b1, KindEmpty);
          end
          hdr.forward = 1'b1;
        end else if (seg.ackn > acked_hi) begin
          acked_hi = seg.ackn;
        end
      end
    end else if (seg.action == ActConnect) begin
      hdr     = header_at(1'b1, 1'b0, KindEmpty);
      own_seq = own_seq + 32'd1;
    end else if (seg.action == ActNext) begin
      if (link_st == LinkEst) begin
        hdr     = header_at(1'b0, 1'b0, srv_role ? KindServer : KindClient);
        own_seq = own_seq + {16'd0, (srv_role ? srv_len : cli_len)};
      end else begin
        hdr = header_at(1'b0, 1'b0, KindEmpty);
      end
    end
    hdr.conn_state = link_st;
    hdr.acked      = acked_hi;
    return hdr;
  endfunction

  // Register write as the model sees it.
  function automatic void load_register(input logic [1:0] idx, input logic [31:0] data);
    case (idx)
      CfgLocalPort: port_cfg = data[15:0];
      CfgInitSeq: begin
        isn_cfg  = data;
        own_seq  = data;
        acked_hi = data;
      end
      CfgClientLen: cli_len = data[15:0];
      CfgServerLen: srv_len = data[15:0];
      default: ;
    endcase
  endfunction

  // Random item for the established state: mostly well-formed traffic.
  function automatic segment_t make_segment();
    segment_t seg;
    int       r;
    seg.action = 2'($urandom_range(0, 3));
    seg.syn    = 1'($urandom_range(0, 1));
    seg.ack    = 1'($urandom_range(0, 1));
    seg.seq    = $urandom();
    seg.ackn   = $urandom();
    seg.bits   = $urandom_range(0, 1) ? 19'($urandom_range(0, 2047)) : 19'($urandom());
    r = $urandom_range(0, 99);
    if (r < 35) begin
      // In-order data.
      seg.action = ActRecv;
      seg.ack    = 1'b0;
      seg.syn    = ($urandom_range(0, 9) == 0);
      seg.seq    = peer_seq;
    end else if (r < 50) begin
      // Acknowledgement, often just ahead of the highest one seen.
      seg.action = ActRecv;
      seg.ack    = 1'b1;
      seg.syn    = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 2))
        0: seg.ackn = acked_hi + $urandom_range(1, 1000);
        1: seg.ackn = acked_hi - $urandom_range(0, 1000);
        default: ;
      endcase
    end else if (r < 65) begin
      seg.action = ActNext;
    end else if (r < 72) begin
      // Out-of-order data.
      seg.action = ActRecv;
      seg.ack    = 1'b0;
      seg.seq    = peer_seq + $urandom_range(1, 5000);
    end else if (r < 80) begin
      seg.action = ActConnect;
    end else if (r < 85) begin
      seg.action = ActUnknown;
    end
    return seg;
  endfunction

  // Offer one item, wait for it to be taken, then maybe pause.
  task automatic send_segment(input segment_t seg, input logic typed, input result_t typed_hdr);
    result_t predicted;
    int      gap;
    in_valid_i        <= 1'b1;
    action_i          <= seg.action;
    in_syn_i          <= seg.syn;
    in_ack_i          <= seg.ack;
    in_seq_number_i   <= seg.seq;
    in_ack_number_i   <= seg.ackn;
    in_payload_bits_i <= seg.bits;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = advance_endpoint(seg);
    expected_hdrs.push_back(typed ? typed_hdr : predicted);
    n_items++;
    gap = quiet_tx ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Write the selected registers back to back while the block is idle.
  task automatic write_registers(input logic [3:0] mask, input logic [31:0] port,
                                 input logic [31:0] isn, input logic [31:0] cli,
                                 input logic [31:0] srv);
    logic [1:0]  idx;
    logic [31:0] data;
    for (int r = 0; r < 4; r++) begin
      if (mask[r]) begin
        idx = r[1:0];
        case (idx)
          CfgLocalPort: data = port;
          CfgInitSeq:   data = isn;
          CfgClientLen: data = cli;
          default:      data = srv;
        endcase
        cfg_valid_i <= 1'b1;
        cfg_index_i <= idx;
        cfg_data_i  <= data;
        @(posedge clk_i);
        while (!cfg_ready_o) @(posedge clk_i);
        load_register(idx, data);
        n_writes++;
      end
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every owed header has arrived and the pipeline is empty.
  task automatic wait_drained();
    while (expected_hdrs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic add_row(input role_e role, input logic [1:0] action, input logic syn,
                         input logic ack, input logic [31:0] seq, input logic [31:0] ackn,
                         input logic [18:0] bits, input logic from_peer,
                         input logic typed, input result_t hdr);
    drill_row_t row;
    row.role          = role;
    row.seg.action    = action;
    row.seg.syn       = syn;
    row.seg.ack       = ack;
    row.seg.seq       = seq;
    row.seg.ackn      = ackn;
    row.seg.bits      = bits;
    row.seq_from_peer = from_peer;
    row.typed         = typed;
    row.hdr           = hdr;
    drill.push_back(row);
  endtask

  function automatic result_t hdr_of(input logic pv, input logic syn, input logic ack,
                                     input logic [31:0] seq, input logic [31:0] ackn,
                                     input logic [1:0] kind, input logic fwd,
                                     input logic [1:0] st, input logic [31:0] acked);
    result_t h;
    h.packet_valid = pv;
    h.syn          = syn;
    h.ack          = ack;
    h.seq          = seq;
    h.ackn         = ackn;
    h.kind         = kind;
    h.forward      = fwd;
    h.conn_state   = st;
    h.acked        = acked;
    return h;
  endfunction

  // One line per mismatch, and a count for the verdict.
  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    n_errors++;
    $display("result %0d: %s is 0x%08h, expected 0x%08h", n_results, what, got, want);
  endtask

  // Compare one accepted result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.packet_valid = packet_valid_o;
      got.syn          = out_syn_o;
      got.ack          = out_ack_o;
      got.seq          = out_seq_number_o;
      got.ackn         = out_ack_number_o;
      got.kind         = payload_kind_o;
      got.forward      = forward_o;
      got.conn_state   = conn_state_o;
      got.acked        = acked_sequence_o;
      n_results++;
      if (got.packet_valid === 1'b1) n_headers++;
      if (got.forward === 1'b1) n_forwards++;
      if (expected_hdrs.size() == 0) begin
        log_mismatch("result with nothing outstanding, sequence", got.seq, 32'd0);
      end else begin
        want = expected_hdrs.pop_front();
        if (got.packet_valid !== want.packet_valid)
          log_mismatch("packet_valid", 32'(got.packet_valid), 32'(want.packet_valid));
        if (got.syn !== want.syn)
          log_mismatch("out_syn", 32'(got.syn), 32'(want.syn));
        if (got.ack !== want.ack)
          log_mismatch("out_ack", 32'(got.ack), 32'(want.ack));
        if (got.seq !== want.seq)
          log_mismatch("out_seq_number", got.seq, want.seq);
        if (got.ackn !== want.ackn)
          log_mismatch("out_ack_number", got.ackn, want.ackn);
        if (got.kind !== want.kind)
          log_mismatch("payload_kind", 32'(got.kind), 32'(want.kind));
        if (got.forward !== want.forward)
          log_mismatch("forward", 32'(got.forward), 32'(want.forward));
        if (got.conn_state !== want.conn_state)
          log_mismatch("conn_state", 32'(got.conn_state), 32'(want.conn_state));
        if (got.acked !== want.acked)
          log_mismatch("acked_sequence", got.acked, want.acked);
      end
    end
  end

  // Receiver: random stalls, quiet stretches, and a long hold on request.
  initial begin : result_sink
    int  stall;
    int  stretch;
    bit  quiet_rx;
    out_ready_i = 1'b0;
    stretch     = 0;
    quiet_rx    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      stretch++;
      if (stretch % 64 == 0) quiet_rx = ($urandom_range(0, 3) == 0);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        stall = quiet_rx ? 0 : pick_gap();
        if (stall == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("no progress for %0d cycles", idle_cycles);
      $display("tcp_handshake_ack_tracker test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Directed table, then configuration phases with random traffic.
  initial begin : stimulus
    role_e       role;
    segment_t    seg;
    logic [3:0]  mask;
    logic [31:0] port;
    logic [31:0] isn;
    logic [31:0] cli;
    logic [31:0] srv;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    action_i          = ActRecv;
    in_syn_i          = 1'b0;
    in_ack_i          = 1'b0;
    in_seq_number_i   = '0;
    in_ack_number_i   = '0;
    in_payload_bits_i = '0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = CfgLocalPort;
    cfg_data_i        = '0;
    quiet_tx          = 1'b0;
    hold_pending      = 1'b0;
    n_items           = 0;
    n_results         = 0;
    n_headers         = 0;
    n_forwards        = 0;
    n_writes          = 0;
    n_errors          = 0;
    link_st           = LinkNone;
    srv_role          = 1'b0;
    own_seq           = '0;
    peer_seq          = '0;
    acked_hi          = '0;
    port_cfg          = '0;
    isn_cfg           = '0;
    cli_len           = ClientLenReset;
    srv_len           = ServerLenReset;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The connection opens only once per run, so the seed picks the role.
    role = $urandom_range(0, 1) ? ROLE_SERVER : ROLE_CLIENT;

    // Before any connection: empty header, unknown action, stray packets, SYN.
    add_row(ROLE_ANY, ActNext, 0, 0, 0, 0, 0, 0, 1,
            hdr_of(1, 0, 0, 0, 0, KindEmpty, 0, LinkNone, 0));
    add_row(ROLE_ANY, ActUnknown, 1, 1, '1, '1, '1, 0, 1,
            hdr_of(0, 0, 0, 0, 0, KindEmpty, 0, LinkNone, 0));
    add_row(ROLE_ANY, ActRecv, 0, 1, 5, 9, 0, 0, 1,
            hdr_of(0, 0, 0, 0, 0, KindEmpty, 0, LinkNone, 0));
    add_row(ROLE_ANY, ActRecv, 0, 0, 0, 0, '1, 0, 1,
            hdr_of(0, 0, 0, 0, 0, KindEmpty, 0, LinkNone, 0));
    add_row(ROLE_ANY, ActConnect, 0, 0, 0, 0, 0, 0, 1,
            hdr_of(1, 1, 0, 0, 0, KindEmpty, 0, LinkNone, 0));
    // Server side: SYN with a sequence that wraps, then the final ACK.
    add_row(ROLE_SERVER, ActRecv, 1, 0, '1, 0, 0, 0, 1,
            hdr_of(1, 1, 1, 1, 0, KindEmpty, 0, LinkSynRcvd, 0));
    add_row(ROLE_SERVER, ActRecv, 1, 1, 0, '1, 0, 0, 1,
            hdr_of(0, 0, 0, 0, 0, KindEmpty, 0, LinkSynRcvd, 0));
    add_row(ROLE_SERVER, ActRecv, 0, 0, 0, 0, 0, 0, 1,
            hdr_of(0, 0, 0, 0, 0, KindEmpty, 0, LinkSynRcvd, 0));
    add_row(ROLE_SERVER, ActNext, 0, 0, 0, 0, 0, 0, 1,
            hdr_of(1, 0, 0, 2, 0, KindEmpty, 0, LinkSynRcvd, 0));
    add_row(ROLE_SERVER, ActConnect, 0, 0, 0, 0, 0, 0, 1,
            hdr_of(1, 1, 0, 2, 0, KindEmpty, 0, LinkSynRcvd, 0));
    add_row(ROLE_SERVER, ActRecv, 0, 1, 0, 0, 0, 0, 1,
            hdr_of(0, 0, 0, 0, 0, KindEmpty, 0, LinkEst, 3));
    // Client side: SYN+ACK straight into the established state.
    add_row(ROLE_CLIENT, ActRecv, 1, 1, 32'h7FFF_FFFF, 0, 0, 0, 1,
            hdr_of(1, 0, 1, 1, 32'h8000_0000, KindEmpty, 0, LinkEst, 1));
    // Established: largest and empty in-order data, out-of-order data.
    add_row(ROLE_ANY, ActRecv, 0, 0, 0, 0, '1, 1, 0, '0);
    add_row(ROLE_ANY, ActRecv, 0, 0, 0, 0, 19'd7, 1, 0, '0);
    add_row(ROLE_ANY, ActRecv, 0, 0, 32'h1234_5678, 0, 19'd800, 0, 0, '0);
    add_row(ROLE_ANY, ActNext, 0, 0, 0, 0, 0, 0, 0, '0);
    add_row(ROLE_ANY, ActNext, 1, 1, '1, '1, '1, 0, 0, '0);
    // Acknowledgements: the largest number, then smaller ones that must not win.
    add_row(ROLE_ANY, ActRecv, 0, 1, 0, '1, 0, 0, 1,
            hdr_of(0, 0, 0, 0, 0, KindEmpty, 0, LinkEst, '1));
    add_row(ROLE_ANY, ActRecv, 0, 1, 0, 0, 0, 0, 1,
            hdr_of(0, 0, 0, 0, 0, KindEmpty, 0, LinkEst, '1));
    add_row(ROLE_ANY, ActRecv, 1, 1, 0, 0, 0, 0, 1,
            hdr_of(0, 0, 0, 0, 0, KindEmpty, 0, LinkEst, '1));
    // SYN on in-order data is ignored; connect and unknown while established.
    add_row(ROLE_ANY, ActRecv, 1, 0, 0, 0, 19'd8, 1, 0, '0);
    add_row(ROLE_ANY, ActConnect, 0, 0, 0, 0, 0, 0, 0, '0);
    add_row(ROLE_ANY, ActUnknown, 0, 0, 0, 0, 0, 0, 1,
            hdr_of(0, 0, 0, 0, 0, KindEmpty, 0, LinkEst, '1));

    foreach (drill[i]) begin
      if (drill[i].role == ROLE_ANY || drill[i].role == role) begin
        seg = drill[i].seg;
        if (drill[i].seq_from_peer) seg.seq = peer_seq;
        send_segment(seg, drill[i].typed, drill[i].hdr);
      end
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      mask = 4'hF;
      port = $urandom();
      isn  = $urandom();
      cli  = $urandom_range(0, 1) ? $urandom_range(0, 200) : $urandom();
      srv  = $urandom_range(0, 1) ? $urandom_range(0, 200) : $urandom();
      case (phase)
        0: begin
          port = 32'h0000_FFFF;
          isn  = '1;
          cli  = 0;
          srv  = 0;
        end
        1: begin
          port = 0;
          isn  = 0;
          cli  = 32'h0000_FFFF;
          srv  = 32'h0000_FFFF;
        end
        3: mask = 4'($urandom_range(1, 15));
        4: isn = 32'hFFFF_FFF0;
        default: ;
      endcase
      write_registers(mask, port, isn, cli, srv);

      // One phase holds the output back while items keep coming.
      if (phase == 2) begin
        hold_pending = 1'b1;
        quiet_tx     = 1'b1;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 2 && n == 30) quiet_tx = 1'b0;
        else if (phase != 2 && n % 40 == 0) quiet_tx = ($urandom_range(0, 3) == 0);
        send_segment(make_segment(), 1'b0, '0);
      end
      quiet_tx = 1'b0;
    end

    in_valid_i <= 1'b0;
    wait_drained();

    $display("%s role: %0d items, %0d results checked, %0d headers, %0d forwarded",
             (role == ROLE_SERVER) ? "server" : "client",
             n_items, n_results, n_headers, n_forwards);
    $display("%0d register writes over %0d phases, %0d mismatches",
             n_writes, NumPhases, n_errors);
    if (n_errors == 0) begin
      $display("tcp_handshake_ack_tracker test passed");
    end else begin
      $display("tcp_handshake_ack_tracker test failed");
    end
    $finish;
  end

endmodule

[tcp_handshake_ack_tracker.f]
+incdir+sv
sv/tht_pkg.sv
sv/tht_front.sv
sv/tht_queue.sv
sv/tht_back.sv
sv/tcp_handshake_ack_tracker.sv
bench/tcp_handshake_ack_tracker_test.sv
